// File: design/cta_pkg.sv
// Package with the word types, codes and calendar helper functions of the calendar time adder.
`timescale 1ns / 1ps

package cta_pkg;

    localparam logic [13:0] MinYear    = 14'd1901;
    localparam logic [13:0] MaxYear    = 14'd9999;
    localparam logic [13:0] Hundred    = 14'd100;
    localparam logic [26:0] HundredInv = 27'd5243;   // 2^19 / 100, rounded up

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ADD  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [13:0] year_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_cta_in;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [8:0]  day_of_year_out;
        t_status     status;
    } t_cta_out;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        leap;
    } t_cal_state;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic       wrap;
    } t_day_step;

    // The quotient by 100 comes from a reciprocal multiply, exact for all 14-bit years.
    function automatic logic is_leap(input logic [13:0] year);
        logic [26:0] prod;
        logic [7:0]  quot;
        logic [13:0] rem;
        prod = 27'(year) * HundredInv;
        quot = prod[26:19];
        rem  = year - 14'(14'(quot) * Hundred);
        return (year[1:0] == 2'd0) && ((rem != 14'd0) || (quot[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd2:                    n = leap ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] n;
        case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic t_day_step next_day(input logic [4:0] day, input logic [3:0] month,
                                           input logic leap);
        t_day_step s;
        s.wrap = 1'b0;
        if (day < days_in(month, leap)) begin
            s.day   = day + 5'd1;
            s.month = month;
        end else if (month < 4'd12) begin
            s.day   = 5'd1;
            s.month = month + 4'd1;
        end else begin
            s.day   = 5'd1;
            s.month = 4'd1;
            s.wrap  = 1'b1;
        end
        return s;
    endfunction

endpackage

// File: design/cta_step.sv
// Next calendar state and result word for one load or add word.
`timescale 1ns / 1ps

module cta_step (
    input  cta_pkg::t_cal_state i_state,
    input  cta_pkg::t_cta_in    i_word,
    output cta_pkg::t_cal_state o_state,
    output cta_pkg::t_cta_out   o_word
);
    import cta_pkg::*;

    logic       in_leap;
    logic       next_leap;
    logic       load_ok;
    logic [6:0] ts;
    logic [6:0] tm;
    logic [5:0] th;
    logic [1:0] c_sec;
    logic [1:0] c_min;
    logic [1:0] c_hour;
    logic [5:0] sec_new;
    logic [5:0] min_new;
    logic [4:0] hour_new;
    t_day_step  step1;
    t_day_step  step2;
    logic       wrap;
    logic       overflow;
    t_cal_state ns;
    t_status    st;

    assign in_leap   = is_leap(i_word.year_in);
    assign next_leap = is_leap(i_state.year + 14'd1);

    assign load_ok = (i_word.year_in >= MinYear) && (i_word.year_in <= MaxYear)
                  && (i_word.month_in >= 4'd1) && (i_word.month_in <= 4'd12)
                  && (i_word.day_in >= 5'd1) && (i_word.hour_in < 5'd24)
                  && (i_word.minute_in < 6'd60) && (i_word.second_in < 6'd60)
                  && (i_word.day_in <= days_in(i_word.month_in, in_leap));

    always_comb begin
        ts = 7'(i_state.second) + 7'(i_word.second_in);
        if (ts >= 7'd120) begin
            c_sec = 2'd2; sec_new = 6'(ts - 7'd120);
        end else if (ts >= 7'd60) begin
            c_sec = 2'd1; sec_new = 6'(ts - 7'd60);
        end else begin
            c_sec = 2'd0; sec_new = 6'(ts);
        end

        tm = 7'(i_state.minute) + 7'(i_word.minute_in) + 7'(c_sec);
        if (tm >= 7'd120) begin
            c_min = 2'd2; min_new = 6'(tm - 7'd120);
        end else if (tm >= 7'd60) begin
            c_min = 2'd1; min_new = 6'(tm - 7'd60);
        end else begin
            c_min = 2'd0; min_new = 6'(tm);
        end

        th = 6'(i_state.hour) + 6'(i_word.hour_in) + 6'(c_min);
        if (th >= 6'd48) begin
            c_hour = 2'd2; hour_new = 5'(th - 6'd48);
        end else if (th >= 6'd24) begin
            c_hour = 2'd1; hour_new = 5'(th - 6'd24);
        end else begin
            c_hour = 2'd0; hour_new = 5'(th);
        end
    end

    assign step1 = next_day(i_state.day, i_state.month, i_state.leap);
    assign step2 = next_day(step1.day, step1.month, step1.wrap ? next_leap : i_state.leap);
    assign wrap  = ((c_hour != 2'd0) && step1.wrap) || ((c_hour == 2'd2) && step2.wrap);
    assign overflow = wrap && (i_state.year >= MaxYear);

    always_comb begin
        ns = i_state;
        st = ST_OK;
        if (i_word.opcode == OP_LOAD) begin
            if (load_ok) begin
                ns.day    = i_word.day_in;
                ns.month  = i_word.month_in;
                ns.year   = i_word.year_in;
                ns.hour   = i_word.hour_in;
                ns.minute = i_word.minute_in;
                ns.second = i_word.second_in;
                ns.leap   = in_leap;
            end else begin
                st = ST_BAD_LOAD;
            end
        end else if (overflow) begin
            st = ST_OVERFLOW;
        end else begin
            ns.second = sec_new;
            ns.minute = min_new;
            ns.hour   = hour_new;
            if (c_hour == 2'd1) begin
                ns.day   = step1.day;
                ns.month = step1.month;
            end else if (c_hour == 2'd2) begin
                ns.day   = step2.day;
                ns.month = step2.month;
            end
            if (wrap) begin
                ns.year = i_state.year + 14'd1;
                ns.leap = next_leap;
            end
        end
    end

    assign o_state = ns;

    always_comb begin
        o_word.day_out         = ns.day;
        o_word.month_out       = ns.month;
        o_word.year_out        = ns.year;
        o_word.hour_out        = ns.hour;
        o_word.minute_out      = ns.minute;
        o_word.second_out      = ns.second;
        o_word.day_of_year_out = month_start(ns.month) + 9'(ns.day)
                               + 9'((ns.month > 4'd2) && ns.leap);
        o_word.status          = st;
    end

endmodule

// File: design/calendar_time_adder.sv
// Top level of the calendar time adder: input register, step logic, result register.
// A word accepted into the input register goes through the step logic into the result register.
// Throughput: one word per cycle unless stalled; state updates once per word in the step logic.
// Back-pressure on the result side stalls the input register only when both stages are full.
// Reset is synchronous and active low: it empties both stages and sets 1 January 1901, 00:00:00.
`timescale 1ns / 1ps

module calendar_time_adder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cta_pkg::t_cta_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cta_pkg::t_cta_out o_out_word
);
    import cta_pkg::*;

    logic       r_in_valid;
    t_cta_in    r_in_word;
    logic       r_out_valid;
    t_cta_out   r_out_word;
    t_cal_state r_state;
    t_cal_state n_state;
    t_cta_out   n_out_word;
    logic       adv;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;

    cta_step u_step (
        .i_state (r_state),
        .i_word  (r_in_word),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.day    <= 5'd1;
            r_state.month  <= 4'd1;
            r_state.year   <= MinYear;
            r_state.hour   <= 5'd0;
            r_state.minute <= 6'd0;
            r_state.second <= 6'd0;
            r_state.leap   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (adv && r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (adv && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: tb/calendar_time_adder_tb.sv
// Self-checking testbench of the calendar time adder: directed and random load and add words.
`timescale 1ns / 1ps

module calendar_time_adder_tb;
    import cta_pkg::*;

    localparam int unsigned StallLimit = 2000;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned RandomWords = 450;

    class calendar_checker;
        int unsigned cur_day, cur_month, cur_year, cur_hour, cur_minute, cur_second;
        t_cta_out    expected_readings[$];
        int unsigned failures;
        int unsigned n_checked;

        function new();
            cur_day    = 1;
            cur_month  = 1;
            cur_year   = 1901;
            cur_hour   = 0;
            cur_minute = 0;
            cur_second = 0;
            failures   = 0;
            n_checked  = 0;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned month_days(int unsigned m, int unsigned y);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return leap_year(y) ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        function t_cta_out reading(t_status st);
            t_cta_out    r;
            int unsigned doy;
            doy = cur_day;
            for (int unsigned m = 1; m < cur_month; m++) begin
                doy += month_days(m, cur_year);
            end
            r.day_out         = 5'(cur_day);
            r.month_out       = 4'(cur_month);
            r.year_out        = 14'(cur_year);
            r.hour_out        = 5'(cur_hour);
            r.minute_out      = 6'(cur_minute);
            r.second_out      = 6'(cur_second);
            r.day_of_year_out = 9'(doy);
            r.status          = st;
            return r;
        endfunction

        function t_cta_out step_calendar(t_cta_in w);
            int unsigned ts, tm, th, carry, nd, nm, ny, k;
            bit          ok;
            if (w.opcode == OP_LOAD) begin
                ok = w.year_in >= 1901 && w.year_in <= 9999 && w.month_in >= 1 &&
                     w.month_in <= 12 && w.day_in >= 1 && w.hour_in < 24 &&
                     w.minute_in < 60 && w.second_in < 60;
                if (ok && w.day_in > month_days(w.month_in, w.year_in)) ok = 1'b0;
                if (!ok) return reading(ST_BAD_LOAD);
                cur_day    = w.day_in;
                cur_month  = w.month_in;
                cur_year   = w.year_in;
                cur_hour   = w.hour_in;
                cur_minute = w.minute_in;
                cur_second = w.second_in;
                return reading(ST_OK);
            end
            ts    = cur_second + w.second_in;
            tm    = cur_minute + w.minute_in + ts / 60;
            th    = cur_hour + w.hour_in + tm / 60;
            carry = th / 24;
            nd    = cur_day;
            nm    = cur_month;
            ny    = cur_year;
            ok    = 1'b1;
            k     = 0;
            while (ok && k < carry) begin
                if (nd < month_days(nm, ny)) begin
                    nd++;
                end else if (nm < 12) begin
                    nd = 1;
                    nm++;
                end else if (ny >= 9999) begin
                    ok = 1'b0;
                end else begin
                    nd = 1;
                    nm = 1;
                    ny++;
                end
                k++;
            end
            if (!ok) return reading(ST_OVERFLOW);
            cur_day    = nd;
            cur_month  = nm;
            cur_year   = ny;
            cur_second = ts % 60;
            cur_minute = tm % 60;
            cur_hour   = th % 24;
            return reading(ST_OK);
        endfunction

        function void note_word(t_cta_in w);
            expected_readings.push_back(step_calendar(w));
        endfunction

        function string show(t_cta_out r);
            return $sformatf("%0d-%0d-%0d %0d:%0d:%0d doy %0d status %0d", r.year_out,
                             r.month_out, r.day_out, r.hour_out, r.minute_out,
                             r.second_out, r.day_of_year_out, r.status);
        endfunction

        function void check_word(t_cta_out got);
            t_cta_out exp;
            string    bad;
            n_checked++;
            if (expected_readings.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result word: %s", show(got));
                return;
            end
            exp = expected_readings.pop_front();
            bad = "";
            if (got.day_out !== exp.day_out) bad = {bad, " day"};
            if (got.month_out !== exp.month_out) bad = {bad, " month"};
            if (got.year_out !== exp.year_out) bad = {bad, " year"};
            if (got.hour_out !== exp.hour_out) bad = {bad, " hour"};
            if (got.minute_out !== exp.minute_out) bad = {bad, " minute"};
            if (got.second_out !== exp.second_out) bad = {bad, " second"};
            if (got.day_of_year_out !== exp.day_of_year_out) bad = {bad, " day_of_year"};
            if (got.status !== exp.status) bad = {bad, " status"};
            if (bad != "") begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch in%s: expected %s, got %s", bad, show(exp), show(got));
                end
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_cta_in  i_in_word = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_cta_out o_out_word;

    calendar_checker sb = new();
    int unsigned     idle_cycles = 0;
    bit              held = 1'b0;

    calendar_time_adder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_cta_in make_word(t_opcode op, int unsigned d, int unsigned mo,
                                          int unsigned y, int unsigned h, int unsigned mi,
                                          int unsigned s);
        t_cta_in w;
        w.opcode    = op;
        w.day_in    = 5'(d);
        w.month_in  = 4'(mo);
        w.year_in   = 14'(y);
        w.hour_in   = 5'(h);
        w.minute_in = 6'(mi);
        w.second_in = 6'(s);
        return w;
    endfunction

    function automatic t_cta_in rand_valid_load();
        int unsigned pick, y, mo, len, d, h, mi, s;
        pick = $urandom_range(0, 99);
        if (pick < 8) y = 9999;
        else if (pick < 16) y = $urandom_range(1901, 1910);
        else if (pick < 40) y = 4 * $urandom_range(476, 2499);
        else if (pick < 50) y = 100 * $urandom_range(20, 99);
        else y = $urandom_range(1901, 9999);
        mo = (pick < 8 && $urandom_range(0, 1)) ? 12 : $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) mo = 2;
        len = sb.month_days(mo, y);
        d   = $urandom_range(0, 1) ? len - $urandom_range(0, 1) : $urandom_range(1, len);
        if ($urandom_range(0, 1)) begin
            h  = 23;
            mi = $urandom_range(55, 59);
            s  = $urandom_range(50, 59);
        end else begin
            h  = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s  = $urandom_range(0, 59);
        end
        return make_word(OP_LOAD, d, mo, y, h, mi, s);
    endfunction

    function automatic t_cta_in rand_bad_load();
        t_cta_in     w;
        int unsigned len;
        w   = rand_valid_load();
        len = sb.month_days(w.month_in, w.year_in);
        case ($urandom_range(0, 6))
            0: w.year_in = 14'($urandom_range(0, 1900));
            1: w.year_in = 14'($urandom_range(10000, 16383));
            2: w.month_in = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
            3: w.day_in = (len < 31 && $urandom_range(0, 1)) ? 5'($urandom_range(len + 1, 31))
                                                             : 5'd0;
            4: w.hour_in = 5'($urandom_range(24, 31));
            5: begin
                if ($urandom_range(0, 1)) w.minute_in = 6'($urandom_range(60, 63));
                else w.second_in = 6'($urandom_range(60, 63));
            end
            default: begin
                w        = t_cta_in'($urandom);
                w.opcode = OP_LOAD;
            end
        endcase
        return w;
    endfunction

    function automatic t_cta_in rand_add();
        t_cta_in     w;
        int unsigned r;
        w        = t_cta_in'($urandom);
        w.opcode = OP_ADD;
        r        = $urandom_range(0, 9);
        if (r < 6) begin
            w.hour_in   = 5'($urandom_range(0, 23));
            w.minute_in = 6'($urandom_range(0, 59));
            w.second_in = 6'($urandom_range(0, 59));
            if ($urandom_range(0, 2) == 0) w.hour_in = 5'd0;
        end else if (r < 7) begin
            w.hour_in   = 5'd23;
            w.minute_in = 6'd59;
            w.second_in = 6'd59;
        end
        return w;
    endfunction

    task automatic send(t_cta_in w);
        int unsigned g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send(make_word(OP_ADD, 0, 0, 0, 0, 0, 0));
        send(make_word(OP_LOAD, 31, 12, 9999, 23, 59, 59));
        send(make_word(OP_ADD, 31, 15, 16383, 0, 0, 1));
        send(make_word(OP_ADD, 0, 0, 0, 31, 63, 63));
        send(make_word(OP_LOAD, 28, 2, 2100, 0, 0, 0));
        send(make_word(OP_ADD, 0, 0, 0, 23, 59, 59));
        send(make_word(OP_LOAD, 29, 2, 2100, 0, 0, 0));
        send(make_word(OP_LOAD, 29, 2, 2000, 23, 59, 59));
        send(make_word(OP_ADD, 0, 0, 0, 0, 0, 1));
        send(make_word(OP_LOAD, 29, 2, 2024, 12, 0, 0));
        send(make_word(OP_LOAD, 1, 1, 1900, 0, 0, 0));
        send(make_word(OP_LOAD, 31, 15, 16383, 31, 63, 63));
        send(make_word(OP_LOAD, 0, 1, 2020, 0, 0, 0));
        send(make_word(OP_LOAD, 1, 0, 2020, 0, 0, 0));
        send(make_word(OP_LOAD, 1, 13, 2020, 0, 0, 0));
        send(make_word(OP_LOAD, 31, 4, 2020, 0, 0, 0));
        send(make_word(OP_LOAD, 1, 1, 2020, 24, 0, 0));
        send(make_word(OP_LOAD, 1, 1, 2020, 0, 60, 0));
        send(make_word(OP_LOAD, 1, 1, 2020, 0, 0, 60));
        send(make_word(OP_LOAD, 1, 1, 1901, 0, 0, 0));
        send(make_word(OP_LOAD, 31, 12, 2023, 23, 59, 59));
        send(make_word(OP_ADD, 0, 0, 0, 0, 0, 1));
        send(make_word(OP_LOAD, 30, 12, 9999, 23, 59, 59));
        send(make_word(OP_ADD, 0, 0, 0, 31, 63, 63));
        send(make_word(OP_ADD, 0, 0, 0, 0, 0, 1));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_word(i_in_word);
            if (o_out_valid && i_out_ready) sb.check_word(o_out_word);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < StallLimit) @(posedge i_clk);
        $display("calendar_time_adder_tb: FAIL");
        $finish;
    end

    initial begin
        int unsigned g;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && sb.n_checked >= 80) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int unsigned n = 0; n < RandomWords; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25) send(rand_valid_load());
            else if (r < 40) send(rand_bad_load());
            else send(rand_add());
        end
        i_in_valid <= 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_readings.size() == 0) begin
            $display("calendar_time_adder_tb: PASS");
        end else begin
            $display("calendar_time_adder_tb: FAIL");
        end
        $finish;
    end

endmodule
